// ----- hw/rtl/expanding_ring_pixel_counter_assert.svh -----
// assertion macros for the expanding ring pixel counter
// expect aclk and aresetn in the scope where they are used

`ifndef EXPANDING_RING_PIXEL_COUNTER_ASSERT_SVH
`define EXPANDING_RING_PIXEL_COUNTER_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define ERPC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ERPC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/erpc_pkg.sv -----
// shared constants, types and helpers of the expanding ring pixel counter
// no dependencies
`timescale 1ns / 1ps

package erpc_pkg;

    localparam int OPCODE_W    = 1;
    localparam int COORD_W     = 6;
    localparam int DIM_W       = 7;
    localparam int COUNT_W     = 13;
    localparam int CFG_IDX_W   = 1;
    localparam int S_TDATA_W   = 16;
    localparam int M_TDATA_W   = 16;

    localparam logic [OPCODE_W-1:0]  OP_WRITE = 1'b0;
    localparam logic [OPCODE_W-1:0]  OP_QUERY = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_HEIGHT = 1'b1;

    localparam logic [DIM_W-1:0]   DIM_RESET = 7'd64;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 13'd8191;

    typedef enum logic [5:0] {
        ST_CLEAR  = 6'b000001,
        ST_IDLE   = 6'b000010,
        ST_ROUND  = 6'b000100,
        ST_SCAN   = 6'b001000,
        ST_DRAIN  = 6'b010000,
        ST_FINISH = 6'b100000
    } state_t;

    // zero acts as one, anything above the map size acts as the map size
    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v,
                                                 input int unsigned maxv);
        logic [DIM_W-1:0] r;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (32'(v) > maxv) begin
            r = DIM_W'(maxv);
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

// ----- hw/rtl/erpc_ram.sv -----
// generic simple dual-port ram with one write and one registered read port
// no dependencies
`timescale 1ns / 1ps

module erpc_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- hw/rtl/expanding_ring_pixel_counter.sv -----
// top level of the expanding ring pixel counter: pixel map, ring scan sequencer, result register
// depends on erpc_pkg, erpc_ram and expanding_ring_pixel_counter_assert.svh
`timescale 1ns / 1ps
`include "expanding_ring_pixel_counter_assert.svh"

// Keeps a MAX_WIDTH x MAX_HEIGHT binary pixel map in one single-bit RAM. After reset the
// block clears the map, one pixel a cycle, with s_tready low; configuration writes are
// taken throughout. A pixel write inside the active image goes straight to the RAM. A query
// grows a rectangle around its centre one step per side per round and reads, counts and
// clears the border pixels of each round through the single RAM read port, one pixel per
// cycle, and ends at the first round that finds nothing. A centre outside the active image
// goes straight to the finish state and returns zero. A finished query waits while the
// previous result is still held. The result waits in an output register while further
// items are taken.
module expanding_ring_pixel_counter #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // pos_x [5:0], pos_y [11:6], pixel_value [12], zero [15:13]
    input  logic [erpc_pkg::S_TDATA_W-1:0]  s_tdata,
    // opcode [0]
    input  logic [erpc_pkg::OPCODE_W-1:0]   s_tuser,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // neighbor_count [12:0], zero [15:13]
    output logic [erpc_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic                            cfg_wr_en,
    input  logic [erpc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [erpc_pkg::DIM_W-1:0]      cfg_wdata
);

    import erpc_pkg::*;

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int A_W   = $clog2(DEPTH);
    localparam int X_W   = $clog2(MAX_WIDTH);
    localparam int Y_W   = $clog2(MAX_HEIGHT);
    localparam int C_W   = 9;

    state_t state_reg, state_next;

    logic [DIM_W-1:0]   active_width_reg, active_height_reg;
    logic [A_W-1:0]     clr_addr_reg, clr_addr_next;
    logic [X_W-1:0]     x0_reg, x0_next, x1_reg, x1_next, sx_reg, sx_next;
    logic [Y_W-1:0]     y0_reg, y0_next, y1_reg, y1_next, sy_reg, sy_next;
    logic               row_phase_reg, row_phase_next;
    logic               side_reg, side_next;
    logic               first_round_reg, first_round_next;
    logic [COUNT_W-1:0] found_reg, found_next;
    logic [COUNT_W-1:0] total_reg, total_next;
    logic               chk_pending_reg, chk_pending_next;
    logic [A_W-1:0]     chk_addr_reg, chk_addr_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [COUNT_W-1:0] m_count_reg, m_count_next;

    logic [COORD_W-1:0] in_x, in_y;
    logic               in_value, in_range, s_xfer;
    logic [DIM_W-1:0]   eff_w, eff_h, w_last, h_last;
    logic [X_W-1:0]     scan_x, gx0, gx1;
    logic [Y_W-1:0]     scan_y, gy0, gy1;
    logic [A_W-1:0]     scan_addr, pix_addr;
    logic               scan_done;
    logic               pixel_hit;
    logic [COUNT_W:0]   total_sum;

    logic               ram_we, ram_wdata, ram_re, ram_rdata;
    logic [A_W-1:0]     ram_waddr;

    assign in_x     = s_tdata[COORD_W-1:0];
    assign in_y     = s_tdata[2*COORD_W-1:COORD_W];
    assign in_value = s_tdata[2*COORD_W];

    assign eff_w  = eff_dim(active_width_reg, MAX_WIDTH);
    assign eff_h  = eff_dim(active_height_reg, MAX_HEIGHT);
    assign w_last = eff_w - DIM_W'(1);
    assign h_last = eff_h - DIM_W'(1);

    assign in_range = (C_W'(in_x) < C_W'(eff_w)) && (C_W'(in_y) < C_W'(eff_h));
    assign s_tready = (state_reg == ST_IDLE);
    assign s_xfer   = s_tvalid && s_tready;
    assign pix_addr = A_W'(32'(in_y) * MAX_WIDTH + 32'(in_x));

    // border walk: both side columns top to bottom, then the inner part of top and bottom rows
    assign scan_x    = row_phase_reg ? sx_reg : (side_reg ? x1_reg : x0_reg);
    assign scan_y    = row_phase_reg ? (side_reg ? y1_reg : y0_reg) : sy_reg;
    assign scan_addr = A_W'(32'(scan_y) * MAX_WIDTH + 32'(scan_x));

    // rectangle after one round of growth
    assign gx0 = (x0_reg != '0) ? x0_reg - X_W'(1) : x0_reg;
    assign gx1 = (C_W'(x1_reg) < C_W'(w_last)) ? x1_reg + X_W'(1) : x1_reg;
    assign gy0 = (y0_reg != '0) ? y0_reg - Y_W'(1) : y0_reg;
    assign gy1 = (C_W'(y1_reg) < C_W'(h_last)) ? y1_reg + Y_W'(1) : y1_reg;

    assign pixel_hit = chk_pending_reg && ram_rdata;
    assign total_sum = {1'b0, total_reg} + {1'b0, found_reg};

    always_comb begin
        sx_next        = sx_reg;
        sy_next        = sy_reg;
        side_next      = side_reg;
        row_phase_next = row_phase_reg;
        scan_done      = 1'b0;
        if (!row_phase_reg) begin
            if (!side_reg && (x1_reg != x0_reg)) begin
                side_next = 1'b1;
            end else begin
                side_next = 1'b0;
                if (sy_reg == y1_reg) begin
                    if (C_W'(x1_reg) >= C_W'(x0_reg) + C_W'(2)) begin
                        row_phase_next = 1'b1;
                        sx_next        = x0_reg + X_W'(1);
                    end else begin
                        scan_done = 1'b1;
                    end
                end else begin
                    sy_next = sy_reg + Y_W'(1);
                end
            end
        end else begin
            if (!side_reg && (y1_reg != y0_reg)) begin
                side_next = 1'b1;
            end else begin
                side_next = 1'b0;
                if (C_W'(sx_reg) + C_W'(1) == C_W'(x1_reg)) begin
                    scan_done = 1'b1;
                end else begin
                    sx_next = sx_reg + X_W'(1);
                end
            end
        end
    end

    always_comb begin
        state_next       = state_reg;
        clr_addr_next    = clr_addr_reg;
        x0_next          = x0_reg;
        x1_next          = x1_reg;
        y0_next          = y0_reg;
        y1_next          = y1_reg;
        first_round_next = first_round_reg;
        found_next       = found_reg;
        total_next       = total_reg;
        chk_pending_next = 1'b0;
        chk_addr_next    = chk_addr_reg;
        m_count_next     = m_count_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        ram_we           = 1'b0;
        ram_waddr        = chk_addr_reg;
        ram_wdata        = 1'b0;
        ram_re           = 1'b0;

        // clear each set border pixel in the cycle after its read
        if (pixel_hit) begin
            ram_we     = 1'b1;
            found_next = found_reg + COUNT_W'(1);
        end

        unique case (state_reg)
            ST_CLEAR: begin
                ram_we        = 1'b1;
                ram_waddr     = clr_addr_reg;
                clr_addr_next = clr_addr_reg + A_W'(1);
                if (32'(clr_addr_reg) == DEPTH - 1) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_xfer) begin
                    if (s_tuser == OP_WRITE) begin
                        ram_we    = in_range;
                        ram_waddr = pix_addr;
                        ram_wdata = in_value;
                    end else begin
                        total_next = '0;
                        if (in_range) begin
                            x0_next          = X_W'(in_x);
                            x1_next          = X_W'(in_x);
                            y0_next          = Y_W'(in_y);
                            y1_next          = Y_W'(in_y);
                            first_round_next = 1'b1;
                            found_next       = '0;
                            state_next       = ST_ROUND;
                        end else begin
                            state_next = ST_FINISH;
                        end
                    end
                end
            end
            ST_ROUND: begin
                if (!first_round_reg && (found_reg == '0)) begin
                    state_next = ST_FINISH;
                end else begin
                    total_next = (total_sum > {1'b0, COUNT_MAX}) ? COUNT_MAX
                                                                 : total_sum[COUNT_W-1:0];
                    found_next       = '0;
                    first_round_next = 1'b0;
                    x0_next          = gx0;
                    x1_next          = gx1;
                    y0_next          = gy0;
                    y1_next          = gy1;
                    state_next       = ST_SCAN;
                end
            end
            ST_SCAN: begin
                ram_re           = 1'b1;
                chk_pending_next = 1'b1;
                chk_addr_next    = scan_addr;
                if (scan_done) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_ROUND;
            end
            ST_FINISH: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_count_next  = total_reg;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_CLEAR;
            clr_addr_reg      <= '0;
            chk_pending_reg   <= 1'b0;
            m_tvalid_reg      <= 1'b0;
            active_width_reg  <= DIM_RESET;
            active_height_reg <= DIM_RESET;
        end else begin
            state_reg       <= state_next;
            clr_addr_reg    <= clr_addr_next;
            chk_pending_reg <= chk_pending_next;
            m_tvalid_reg    <= m_tvalid_next;
            if (cfg_wr_en) begin
                if (cfg_index == REG_ACTIVE_WIDTH) begin
                    active_width_reg <= cfg_wdata;
                end else if (cfg_index == REG_ACTIVE_HEIGHT) begin
                    active_height_reg <= cfg_wdata;
                end
            end
        end
    end

    // scan and result payload, set before use
    always_ff @(posedge aclk) begin
        x0_reg          <= x0_next;
        x1_reg          <= x1_next;
        y0_reg          <= y0_next;
        y1_reg          <= y1_next;
        first_round_reg <= first_round_next;
        found_reg       <= found_next;
        total_reg       <= total_next;
        chk_addr_reg    <= chk_addr_next;
        m_count_reg     <= m_count_next;
        if (state_reg == ST_ROUND) begin
            sx_reg        <= gx0;
            sy_reg        <= gy0;
            side_reg      <= 1'b0;
            row_phase_reg <= 1'b0;
        end else if (state_reg == ST_SCAN) begin
            sx_reg        <= sx_next;
            sy_reg        <= sy_next;
            side_reg      <= side_next;
            row_phase_reg <= row_phase_next;
        end
    end

    erpc_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_pixel_map (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (scan_addr),
        .rd_data (ram_rdata)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_W'(m_count_reg);

    `ERPC_ASSERT_NOW(a_no_read_write_clash, ram_re && ram_we, ram_waddr != scan_addr, "border read hits the pixel being cleared")
    `ERPC_ASSERT_NOW(a_result_from_finish, $rose(m_tvalid_reg), $past(state_reg == ST_FINISH), "result loaded outside finish")
    `ERPC_ASSERT_NEXT(a_query_starts, s_tvalid && s_tready && (s_tuser == OP_QUERY), (state_reg == ST_ROUND) || (state_reg == ST_FINISH), "accepted query did not start")

endmodule
